>>> hdl/contiguous_slot_allocator_macros.svh
// Assertion macros for the contiguous slot allocator checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef CONTIGUOUS_SLOT_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/csa_pkg.sv
// Shared constants, codes and control structs for the contiguous slot allocator.
// No dependencies; used by all allocator modules and the checker.
package csa_pkg;

    localparam int SLOTS_DEFAULT   = 60;
    localparam int CHUNK           = 8;    // slots examined per scan cycle
    localparam int SLOT_BYTES_LOG2 = 3;    // 8 name bytes per slot

    localparam int LEN_W    = 9;
    localparam int POS_W    = 6;
    localparam int START_W  = 6;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 7;           // holds slot counts up to 64

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 8;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOROOM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD    = 2'd2;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_done;
    } dp_stat_t;

endpackage

>>> hdl/csa_datapath.sv
// Datapath: occupancy bitmap, request registers, chunked first-fit scan, result register.
// Depends on csa_pkg; driven by csa_ctrl through ctrl_cmd_t / dp_stat_t.
module csa_datapath #(
    parameter int SLOTS = csa_pkg::SLOTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  csa_pkg::ctrl_cmd_t            cmd,
    output csa_pkg::dp_stat_t             stat,
    input  logic                          req_cmd,
    input  logic [csa_pkg::LEN_W-1:0]     req_len,
    input  logic [csa_pkg::POS_W-1:0]     req_pos,
    output logic [csa_pkg::M_DATA_W-1:0]  res_data
);

    localparam int NCHUNK = (SLOTS + csa_pkg::CHUNK - 1) / csa_pkg::CHUNK;
    localparam int SCAN_W = NCHUNK * csa_pkg::CHUNK;
    localparam int CW     = csa_pkg::CNT_W;

    logic [SLOTS-1:0]                occ_reg, occ_next;
    logic [SCAN_W-1:0]               scan_reg, scan_next;
    logic                            cmd_reg, cmd_next;
    logic [CW-1:0]                   n_reg, n_next;
    logic [csa_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [CW-1:0]                   base_reg, base_next;
    logic [CW-1:0]                   run_reg, run_next;
    logic                            found_reg, found_next;
    logic [CW-1:0]                   start_reg, start_next;
    logic [csa_pkg::M_DATA_W-1:0]    data_reg, data_next;

    logic [SLOTS-1:0]                run_mask;
    logic [csa_pkg::START_W-1:0]     res_start;
    logic [csa_pkg::STATUS_W-1:0]    res_status;
    logic [csa_pkg::POS_W+1:0]       free_end;

    assign stat.need_scan = (cmd_reg == csa_pkg::CMD_ALLOC) && (n_reg != '0)
                          && (n_reg <= CW'(SLOTS));
    assign stat.scan_done = found_reg || (base_reg == CW'(SCAN_W));
    assign res_data       = data_reg;

    // n low ones, n up to 64
    assign run_mask = ~({SLOTS{1'b1}} << n_reg);
    assign free_end = (csa_pkg::POS_W+2)'(pos_reg) + (csa_pkg::POS_W+2)'(n_reg);

    // scan step: eight slots in order, run length tracked across chunks
    always_comb
    begin
        logic [CW-1:0] run_v;
        logic [CW-1:0] st_v;
        logic [CW-1:0] idx_v;
        logic          found_v;
        run_v   = run_reg;
        st_v    = start_reg;
        found_v = found_reg;
        for (int i = 0; i < csa_pkg::CHUNK; i++)
        begin
            idx_v = base_reg + CW'(i);
            if (!found_v)
            begin
                run_v = scan_reg[i] ? '0 : run_v + CW'(1);
                if (run_v == n_reg)
                begin
                    found_v = 1'b1;
                    st_v    = idx_v + CW'(1) - n_reg;
                end
            end
        end
        run_next   = run_v;
        start_next = st_v;
        found_next = found_v;
    end

    // result and bitmap update
    always_comb
    begin
        occ_next   = occ_reg;
        res_start  = csa_pkg::START_W'(SLOTS);
        res_status = csa_pkg::ST_DONE;
        if (cmd_reg == csa_pkg::CMD_ALLOC)
        begin
            if (n_reg == '0)
                res_status = csa_pkg::ST_BAD;
            else if (found_reg && stat.need_scan)
            begin
                res_start = start_reg[csa_pkg::START_W-1:0];
                occ_next  = occ_reg | (run_mask << start_reg);
            end
            else
                res_status = csa_pkg::ST_NOROOM;
        end
        else
        begin
            res_start = pos_reg;
            if (n_reg == '0 || free_end > (csa_pkg::POS_W+2)'(SLOTS))
                res_status = csa_pkg::ST_BAD;
            else
                occ_next = occ_reg & ~(run_mask << pos_reg);
        end
        data_next = {res_status, res_start};
    end

    // bitmap; beyond-end slots read as used during the scan
    assign scan_next = SCAN_W'(occ_reg) | ~(SCAN_W'({SLOTS{1'b1}}));
    assign cmd_next  = req_cmd;
    assign pos_next  = req_pos;
    assign n_next    = CW'(((csa_pkg::LEN_W+1)'(req_len) + (csa_pkg::LEN_W+1)'(7))
                           >> csa_pkg::SLOT_BYTES_LOG2);
    assign base_next = base_reg + CW'(csa_pkg::CHUNK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else if (cmd.commit)
            occ_reg <= occ_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= cmd_next;
            n_reg     <= n_next;
            pos_reg   <= pos_next;
            scan_reg  <= scan_next;
            base_reg  <= '0;
            run_reg   <= '0;
            found_reg <= 1'b0;
            start_reg <= '0;
        end
        else if (cmd.step)
        begin
            scan_reg  <= scan_reg >> csa_pkg::CHUNK;
            base_reg  <= base_next;
            run_reg   <= run_next;
            found_reg <= found_next;
            start_reg <= start_next;
        end
        if (cmd.commit)
            data_reg <= data_next;
    end

endmodule

>>> hdl/csa_ctrl.sv
// Controller: accepts one request, sequences the scan, commits into the result register.
// Depends on csa_pkg; drives csa_datapath through ctrl_cmd_t.
module csa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  csa_pkg::dp_stat_t   stat,
    output csa_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic {
        IDLE,
        RUN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   work_left;
    logic   out_free;

    always_comb
    begin
        s_tready   = (state_reg == IDLE);
        work_left  = stat.need_scan && !stat.scan_done;
        out_free   = !out_valid_reg || m_tready;
        cmd.load   = s_tvalid && s_tready;
        cmd.step   = (state_reg == RUN) && work_left;
        cmd.commit = (state_reg == RUN) && !work_left && out_free;

        state_next = state_reg;
        case (state_reg)
            IDLE:    if (cmd.load) state_next = RUN;
            RUN:     if (cmd.commit) state_next = IDLE;
            default: state_next = IDLE;
        endcase

        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hdl/contiguous_slot_allocator.sv
// Contiguous slot allocator: first-fit run allocation over a bitmap of SLOTS slots.
// Free commits without a scan; an allocate of 1 to SLOTS slots first runs the chunked
// first-fit scan, 8 bitmap slots per cycle over ceil(SLOTS/8) chunks at most.
// Throughput: one item in flight; next item accepted the cycle after its result is built.
// Reset: rst_n asynchronous active low; all slots free, no result pending, ready for input.
module contiguous_slot_allocator #(
    parameter int SLOTS = csa_pkg::SLOTS_DEFAULT   // 8 to 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [csa_pkg::S_DATA_W-1:0]  s_tdata,   // [8:0] name_length, [14:9] position,
                                                     // [15] zero
    input  logic [0:0]                    s_tuser,   // [0] cmd: 0 allocate, 1 free
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [csa_pkg::M_DATA_W-1:0]  m_tdata    // [5:0] slot_start, [7:6] status
);

    csa_pkg::ctrl_cmd_t ctrl_cmd;
    csa_pkg::dp_stat_t  dp_stat;

    // Controller: IDLE takes an item; RUN steps the scan then commits once
    // the result register is free. A pending result does not block accept.
    csa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (dp_stat),
        .cmd      (ctrl_cmd)
    );

    // Datapath: bitmap, request latch, scan window, result register.
    csa_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (ctrl_cmd),
        .stat     (dp_stat),
        .req_cmd  (s_tuser[0]),
        .req_len  (s_tdata[csa_pkg::LEN_W-1:0]),
        .req_pos  (s_tdata[csa_pkg::LEN_W +: csa_pkg::POS_W]),
        .res_data (m_tdata)
    );

endmodule

>>> hdl/csa_checker.sv
// Port-level checker for the contiguous slot allocator, bound to the top level.
// Depends on csa_pkg and contiguous_slot_allocator_macros.svh.
`include "contiguous_slot_allocator_macros.svh"

module csa_checker #(
    parameter int SLOTS = csa_pkg::SLOTS_DEFAULT
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [csa_pkg::S_DATA_W-1:0]  s_tdata,
    input logic [0:0]                    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [csa_pkg::M_DATA_W-1:0]  m_tdata
);

    logic [csa_pkg::START_W-1:0]  chk_start;
    logic [csa_pkg::STATUS_W-1:0] chk_status;

    assign chk_start  = m_tdata[csa_pkg::START_W-1:0];
    assign chk_status = m_tdata[csa_pkg::M_DATA_W-1:csa_pkg::START_W];

    `CSA_ASSERT_NEXT(a_hold_result, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    `CSA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready, "second item taken while one in flight")

    `CSA_ASSERT_NOW(a_status_code, clk, rst_n, m_tvalid, chk_status == csa_pkg::ST_DONE || chk_status == csa_pkg::ST_NOROOM || chk_status == csa_pkg::ST_BAD, "undefined status")

    `CSA_ASSERT_NOW(a_noroom_start, clk, rst_n, m_tvalid && chk_status == csa_pkg::ST_NOROOM, chk_start == csa_pkg::START_W'(SLOTS), "no-room result without end marker")

endmodule

bind contiguous_slot_allocator csa_checker #(.SLOTS(SLOTS)) u_csa_checker (.*);
